FILE: sv/scmm_pkg.sv
// ============================================================================
// scmm_pkg - shared constants for the six-channel moving median filter
// Holds the channel count and the helper that sizes the per-cell age field.
// ============================================================================
package scmm_pkg;

    // Number of independent sample channels (x, y, z, roll, pitch, yaw).
    localparam int unsigned NUM_CHANNELS = 6;

    // Bits needed for an age tag in 0 .. window-1, at least one bit.
    function automatic int unsigned age_width(input int unsigned window);
        int unsigned bits;
        bits = 1;
        while ((1 << bits) < window) begin
            bits = bits + 1;
        end
        return bits;
    endfunction

endpackage

FILE: sv/six_channel_moving_median_top.sv
// ============================================================================
// six_channel_moving_median_top - six-channel sliding-window median filter
// Per channel, returns the value at sorted position WINDOW/2 of the last
// WINDOW samples; unwritten slots count as zero after reset.
// ============================================================================
// Path: an accepted beat waits in the input register, then its medians
//   are registered in the result register until the sink takes them.
// Throughput: one beat per cycle while the sink keeps up; the sorted cell
//   chain of each channel drops the oldest entry and inserts the new one in one update.
// Reset: synchronous, active low; every window cell reads as zero, both
//   stages are emptied, and the block accepts beats in the next cycle.
module six_channel_moving_median_top #(
    parameter int unsigned WINDOW      = 16,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // Fields from bit 0 up: sample_x, sample_y, sample_z, sample_roll,
    // sample_pitch, sample_yaw, each SAMPLE_BITS wide, then zero fill.
    input  logic [((scmm_pkg::NUM_CHANNELS * SAMPLE_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // Output stream.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // Fields from bit 0 up: median_x, median_y, median_z, median_roll,
    // median_pitch, median_yaw, each SAMPLE_BITS wide, then zero fill.
    output logic [((scmm_pkg::NUM_CHANNELS * SAMPLE_BITS + 7) / 8) * 8 - 1:0] o_m_axis_tdata
);

    localparam int unsigned NCH     = scmm_pkg::NUM_CHANNELS;

    // Input register: holds one accepted beat until the chains take it.
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_data [NCH];

    // Result register: holds the medians until the sink takes them.
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_data [NCH];

    logic                   advance;
    logic [SAMPLE_BITS-1:0] median_next [NCH];

    // The chains advance whenever a beat waits and the result slot is free
    // or being emptied in this cycle.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            for (int c = 0; c < NCH; c++) begin
                r_in_data[c] <= i_s_axis_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    // One sorted chain per channel; all chains move in lockstep, which
    // keeps the oldest-slot order shared across channels.
    for (genvar c = 0; c < NCH; c++) begin : g_chain
        scmm_sort_chain #(
            .WINDOW      (WINDOW),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_chain (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (advance),
            .i_sample (r_in_data[c]),
            .o_median (median_next[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int c = 0; c < NCH; c++) begin
                r_out_data[c] <= median_next[c];
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;

    always_comb begin
        o_m_axis_tdata = '0;
        for (int c = 0; c < NCH; c++) begin
            o_m_axis_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] = r_out_data[c];
        end
    end

endmodule

FILE: sv/scmm_sort_chain.sv
// ============================================================================
// scmm_sort_chain - sorted cell chain for one channel
// Keeps the window sorted by value; each load drops the oldest cell and
// inserts the new sample in one update, and shows the middle cell of the
// updated chain.
// ============================================================================
module scmm_sort_chain #(
    parameter int unsigned WINDOW      = 16,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_median
);

    localparam int unsigned AW  = scmm_pkg::age_width(WINDOW);
    localparam int unsigned MID = WINDOW / 2;
    localparam logic [AW-1:0] OLDEST_AGE = AW'(WINDOW - 1);

    // Each cell holds a value and its age; the chain is sorted ascending.
    logic signed [SAMPLE_BITS-1:0] r_val [WINDOW];
    logic        [AW-1:0]          r_age [WINDOW];
    logic signed [SAMPLE_BITS-1:0] n_val [WINDOW];
    logic        [AW-1:0]          n_age [WINDOW];

    logic [WINDOW-1:0] del;        // the cell that leaves this beat
    logic [WINDOW-1:0] lt;         // cell value below the new sample
    logic [WINDOW-1:0] before_del; // cell index below the leaving cell
    logic [WINDOW-1:0] rlt;        // remaining list entry below new sample

    logic signed [SAMPLE_BITS-1:0] rv [WINDOW];
    logic        [AW-1:0]          ra [WINDOW];

    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            del[i] = (r_age[i] == OLDEST_AGE);
            lt[i]  = (r_val[i] < i_sample);
        end
        // Cells below the leaving one keep their place; the rest close up.
        before_del[WINDOW-1] = 1'b0;
        for (int i = WINDOW - 2; i >= 0; i--) begin
            before_del[i] = before_del[i+1] | del[i+1];
        end
        for (int i = 0; i < WINDOW; i++) begin
            if (i < WINDOW - 1) begin
                if (before_del[i]) begin
                    rv[i]  = r_val[i];
                    ra[i]  = r_age[i];
                    rlt[i] = lt[i];
                end else begin
                    rv[i]  = r_val[i+1];
                    ra[i]  = r_age[i+1];
                    rlt[i] = lt[i+1];
                end
            end else begin
                rv[i]  = r_val[i];
                ra[i]  = r_age[i];
                rlt[i] = 1'b0;
            end
        end
        // Insert the new sample at the first remaining entry not below it.
        for (int i = 0; i < WINDOW; i++) begin
            if (rlt[i]) begin
                n_val[i] = rv[i];
                n_age[i] = AW'(ra[i] + 1'b1);
            end else if (i == 0) begin
                n_val[i] = i_sample;
                n_age[i] = '0;
            end else if (rlt[i-1]) begin
                n_val[i] = i_sample;
                n_age[i] = '0;
            end else begin
                n_val[i] = rv[i-1];
                n_age[i] = AW'(ra[i-1] + 1'b1);
            end
        end
    end

    assign o_median = n_val[MID];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_val[i] <= '0;
                r_age[i] <= AW'(i);
            end
        end else if (i_load) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_val[i] <= n_val[i];
                r_age[i] <= n_age[i];
            end
        end
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench - self-checking bench for the six-channel moving median filter
// Streams six-channel samples into the filter under random idling on both
// sides. A behavioral copy of the sliding windows predicts the per-channel
// median of every accepted beat, and each output beat is checked against it.
// ============================================================================
module testbench;

    localparam int unsigned NUM_CHANNELS = scmm_pkg::NUM_CHANNELS;
    localparam int unsigned WINDOW      = 16;
    localparam int unsigned SAMPLE_BITS = 16;
    localparam int unsigned MEDIAN_POS  = WINDOW / 2;
    localparam int unsigned TDATA_W     = ((NUM_CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
    // Cycles without any accepted beat on either side before the run is abandoned.
    localparam int unsigned STALL_LIMIT = 4000;
    // A beat passes the input and result registers before it shows; these edges are spare.
    localparam int unsigned TAIL_CYCLES = 6;
    localparam int unsigned IDLE_PCT    = 28;
    localparam int unsigned PRINT_CAP   = 100;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [TDATA_W-1:0]            t_beat;

    // Clock, reset and stream signals; every input is known from time zero.
    logic  i_clk    = 1'b0;
    logic  i_rst_n  = 1'b0;
    logic  s_tvalid = 1'b0;
    t_beat s_tdata  = '0;
    logic  m_tready = 1'b0;
    logic  s_tready;
    logic  m_tvalid;
    t_beat m_tdata;

    // When set, neither side idles.
    logic steady = 1'b0;

    // Predicted state: the last WINDOW samples of each channel and the slot
    // that the next sample overwrites.
    t_sample     history [NUM_CHANNELS][WINDOW];
    int unsigned next_slot = 0;

    // Predicted output beats, oldest first.
    t_beat       median_queue [$];
    t_beat       oldest_median;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;

    string channel_name [NUM_CHANNELS] = '{"x", "y", "z", "roll", "pitch", "yaw"};

    six_channel_moving_median_top #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        // Fields from bit 0 up: sample_x, sample_y, sample_z, sample_roll,
        // sample_pitch, sample_yaw.
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        // Fields from bit 0 up: median_x, median_y, median_z, median_roll,
        // median_pitch, median_yaw.
        .o_m_axis_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            for (int k = 0; k < WINDOW; k++) begin
                history[c][k] = '0;
            end
        end
    end

    // Every mismatch lands here; printing stops after a cap but counting goes on.
    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
        error_count++;
    endtask

    // Writes one sample into the windows and returns the median of each channel.
    // The sorted copy of each window is taken after the new sample is in place,
    // so slots still zero from reset take part in the median as zeros.
    function automatic t_beat window_median(input t_beat beat);
        t_sample ordered [WINDOW];
        t_sample pick;
        t_beat   medians;
        int      j;
        medians = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            history[c][next_slot] = beat[c*SAMPLE_BITS +: SAMPLE_BITS];
        end
        next_slot = (next_slot + 1 == WINDOW) ? 0 : next_slot + 1;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            for (int k = 0; k < WINDOW; k++) begin
                ordered[k] = history[c][k];
            end
            for (int i = 1; i < WINDOW; i++) begin
                pick = ordered[i];
                j = i - 1;
                while (j >= 0 && ordered[j] > pick) begin
                    ordered[j+1] = ordered[j];
                    j--;
                end
                ordered[j+1] = pick;
            end
            medians[c*SAMPLE_BITS +: SAMPLE_BITS] = ordered[MEDIAN_POS];
        end
        return medians;
    endfunction

    // Builds a beat with the same value on every channel.
    function automatic t_beat uniform_beat(input t_sample value);
        t_beat beat;
        beat = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            beat[c*SAMPLE_BITS +: SAMPLE_BITS] = value;
        end
        return beat;
    endfunction

    // Random beat: mostly full-range values, some tight clusters that force
    // ties inside the window, and some values at or next to the extremes.
    function automatic t_beat random_beat();
        t_beat       beat;
        t_sample     extremes [6];
        int unsigned kind;
        int          base;
        extremes = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh8001};
        beat = '0;
        kind = $urandom_range(0, 99);
        base = int'($urandom_range(0, 200)) - 100;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (kind < 60) begin
                beat[c*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'($urandom);
            end else if (kind < 85) begin
                beat[c*SAMPLE_BITS +: SAMPLE_BITS] =
                    SAMPLE_BITS'(base + int'($urandom_range(0, 4)) - 2);
            end else begin
                beat[c*SAMPLE_BITS +: SAMPLE_BITS] = extremes[$urandom_range(0, 5)];
            end
        end
        return beat;
    endfunction

    // Output side: the ready line idles at random unless a steady stretch runs.
    always @(negedge i_clk) begin
        m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Scoreboard. The output beat is checked before the input beat of the
    // same edge is predicted; the latter must pass both registers to show up.
    // The watchdog runs in the same process and is the last thing it does.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (median_queue.size() == 0) begin
                    report_mismatch("output beat arrived with no sample waiting");
                end else begin
                    oldest_median = median_queue.pop_front();
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] !==
                                oldest_median[c*SAMPLE_BITS +: SAMPLE_BITS]) begin
                            report_mismatch($sformatf("median_%s got %0d expected %0d",
                                channel_name[c],
                                $signed(m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]),
                                $signed(oldest_median[c*SAMPLE_BITS +: SAMPLE_BITS])));
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                median_queue.push_back(window_median(s_tdata));
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[%0t] no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Sends one sample. Called at a falling edge and returns at a falling edge
    // with tvalid still high, so back-to-back beats never drop tvalid.
    task automatic send_sample(input t_beat beat);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        @(negedge i_clk);
    endtask

    // Lowers tvalid and waits until every predicted median has been checked.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (median_queue.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Fill phase: right after reset most slots still hold zero, so the
    // median is pulled toward zero until the window has filled up.
    task automatic test_fill_phase();
        t_beat beat;
        for (int k = 0; k < 6; k++) begin
            beat = '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                beat[c*SAMPLE_BITS +: SAMPLE_BITS] =
                    SAMPLE_BITS'((c % 2 == 0) ? (k + 1) * 1000 + c : -(k + 1) * 1000 - c);
            end
            send_sample(beat);
        end
    endtask

    // Field extremes and alternating bit patterns on every channel.
    task automatic test_extremes();
        send_sample(uniform_beat(16'sh8000));
        send_sample(uniform_beat(16'sh7FFF));
        send_sample(uniform_beat(16'shFFFF));
        send_sample(uniform_beat(16'sh0000));
        send_sample(uniform_beat(16'sh5555));
        send_sample(uniform_beat(16'shAAAA));
        send_sample({16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000});
        send_sample({16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
    endtask

    // Equal values: a run of identical samples, then one that breaks the tie.
    task automatic test_equal_values();
        for (int k = 0; k < 7; k++) begin
            send_sample(uniform_beat(16'sd5));
        end
        send_sample(uniform_beat(-16'sd7));
    endtask

    // The sender holds off until every predicted median has come back, then
    // resumes; the windows must carry across the pause untouched.
    task automatic test_pause_and_resume();
        for (int k = 0; k < 20; k++) begin
            send_sample(random_beat());
        end
        drain_results();
        for (int k = 0; k < 20; k++) begin
            send_sample(random_beat());
        end
    endtask

    // Bulk random traffic with a stretch in the middle where nobody idles.
    task automatic test_random_stream();
        for (int k = 0; k < 1100; k++) begin
            steady = (k >= 400 && k < 700);
            send_sample(random_beat());
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_fill_phase();
        test_extremes();
        test_equal_values();
        test_pause_and_resume();
        test_random_stream();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/scmm_pkg.sv
sv/scmm_sort_chain.sv
sv/six_channel_moving_median_top.sv
tb/sv/testbench.sv
